// ===== hw/rtl/crcfg_pkg.sv =====
package crcfg_pkg;

  localparam int unsigned CrcW  = 16;
  localparam int unsigned ByteW = 8;

  // Configuration register indexes.
  localparam logic CFG_CHECK_MODE = 1'b0;
  localparam logic CFG_INIT_VALUE = 1'b1;

  // What one queued record turns into on the result channel.
  typedef enum logic [1:0] {
    REC_BYTE    = 2'd0,  // one passed-through byte
    REC_GEN_END = 2'd1,  // last byte, then CRC high and low byte
    REC_CHECK   = 2'd2   // one check verdict
  } rec_kind_t;

  typedef struct packed {
    rec_kind_t             kind;
    logic [ByteW-1:0]      data;
    logic [CrcW-1:0]       crc;
    logic                  ok;
  } rec_t;

  // Record queue head as seen by the result serializer.
  typedef struct packed {
    logic valid;
    rec_t rec;
  } rec_head_t;

  // Reflected CRC-16 (0xA001) nibble table.
  function automatic logic [CrcW-1:0] nib_lookup(input logic [3:0] n);
    logic [CrcW-1:0] v;
    case (n)
      4'h0: v = 16'h0000;
      4'h1: v = 16'hCC01;
      4'h2: v = 16'hD801;
      4'h3: v = 16'h1400;
      4'h4: v = 16'hF001;
      4'h5: v = 16'h3C00;
      4'h6: v = 16'h2800;
      4'h7: v = 16'hE401;
      4'h8: v = 16'hA001;
      4'h9: v = 16'h6C00;
      4'hA: v = 16'h7800;
      4'hB: v = 16'hB401;
      4'hC: v = 16'h5000;
      4'hD: v = 16'h9C01;
      4'hE: v = 16'h8801;
      default: v = 16'h4400;
    endcase
    return v;
  endfunction

  // One byte, low nibble first.
  function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc,
                                               input logic [ByteW-1:0] b);
    logic [CrcW-1:0] c1;
    c1 = {4'h0, crc[CrcW-1:4]} ^ nib_lookup(crc[3:0]) ^ nib_lookup(b[3:0]);
    return {4'h0, c1[CrcW-1:4]} ^ nib_lookup(c1[3:0]) ^ nib_lookup(b[7:4]);
  endfunction

endpackage

// ===== hw/rtl/crc16_frame_generate_check.sv =====
// Channel  Dir  Handshake            Payload
// in_      in   in_tvalid/in_tready  tdata[7:0] data byte, tlast last byte of frame
// out_     out  out_tvalid/out_tready tdata[7:0] byte, tdata[23:8] CRC, tlast, tuser ok
// cfg_     in   cfg_wr_en            cfg_addr 0 check_mode, 1 init_value; cfg_wdata
//
// The block takes one item per cycle while the record queue has room. The CRC
// update for a byte is two nibble table steps done in the cycle the item is
// accepted, and the result record goes into a two-entry queue that keeps
// in_tready free of any path from out_tready. In generate mode the last byte of
// a frame gives three result items, so the queue can fill and stall the input.
// Reset is synchronous and active low: generate mode, start value zero, no
// frame in progress and nothing queued.
module crc16_frame_generate_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] out_byte, [23:8] crc_value
  output logic        out_tlast,
  output logic        out_tuser,  // [0] crc_ok
  input  logic        cfg_wr_en,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_wdata
);

  logic                 in_accept;
  logic                 push, pop, not_full;
  crcfg_pkg::rec_t      push_rec;
  crcfg_pkg::rec_head_t head;
  logic [7:0]           out_byte;
  logic [15:0]          out_crc;

  // The queue count is a register, so in_tready has no combinational path
  // from the output side.
  assign in_tready = not_full;
  assign in_accept = in_tvalid && in_tready;

  // Frame state, CRC update and check compare.
  crcfg_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_byte   (in_tdata),
    .in_last   (in_tlast),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .push      (push),
    .push_rec  (push_rec)
  );

  // Records are only pushed on accepted items.
  crcfg_rec_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push && in_accept),
    .push_rec (push_rec),
    .pop      (pop),
    .not_full (not_full),
    .head     (head)
  );

  // Unrolls each record into one or three result items.
  crcfg_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_byte),
    .out_last  (out_tlast),
    .out_crc   (out_crc),
    .out_ok    (out_tuser)
  );

  assign out_tdata = {out_crc, out_byte};

  // A passing check is always a frame's last result and carries no byte.
  a_ok_is_check_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && (out_tdata[7:0] == 8'h00))
    else $error("crc_ok set on a result that is not a check verdict");

  // Results before the end of a frame carry no CRC and no match flag.
  a_mid_frame_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> (out_tdata[23:8] == 16'h0000) && !out_tuser)
    else $error("CRC fields set on a result inside a frame");

  // The queue is never popped while empty.
  a_no_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.valid)
    else $error("record queue popped while empty");

endmodule

// ===== hw/rtl/crcfg_core.sv =====
module crcfg_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_accept,
  input  logic [crcfg_pkg::ByteW-1:0]   in_byte,
  input  logic                          in_last,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_addr,
  input  logic [crcfg_pkg::CrcW-1:0]    cfg_wdata,
  output logic                          push,
  output crcfg_pkg::rec_t               push_rec
);

  logic                         check_mode_r;
  logic [crcfg_pkg::CrcW-1:0]   init_value_r;
  logic [crcfg_pkg::CrcW-1:0]   crc_r, crc_nxt;
  logic [crcfg_pkg::ByteW-1:0]  held0_r, held0_nxt, held1_r, held1_nxt;
  logic [1:0]                   cnt_r, cnt_nxt;
  logic [crcfg_pkg::CrcW-1:0]   crc_upd;

  // The CRC absorbs at most one byte per item: the new one when
  // generating, the oldest held one when checking with two bytes held.
  assign crc_upd = crcfg_pkg::crc_byte(crc_r, check_mode_r ? held0_r : in_byte);

  always_comb begin
    crc_nxt   = crc_r;
    held0_nxt = held0_r;
    held1_nxt = held1_r;
    cnt_nxt   = cnt_r;
    push      = 1'b0;
    push_rec  = '{kind: crcfg_pkg::REC_BYTE, data: in_byte,
                  crc: crc_upd, ok: 1'b0};
    if (!check_mode_r) begin
      crc_nxt = crc_upd;
      push    = 1'b1;
      if (in_last) begin
        push_rec.kind = crcfg_pkg::REC_GEN_END;
      end
    end else begin
      if (cnt_r == 2'd2) begin
        crc_nxt   = crc_upd;
        held0_nxt = held1_r;
        held1_nxt = in_byte;
      end else if (cnt_r == 2'd1) begin
        held1_nxt = in_byte;
        cnt_nxt   = 2'd2;
      end else begin
        held0_nxt = in_byte;
        cnt_nxt   = 2'd1;
      end
      push          = in_last;
      push_rec.kind = crcfg_pkg::REC_CHECK;
      push_rec.data = '0;
      push_rec.crc  = crc_nxt;
      push_rec.ok   = (cnt_nxt == 2'd2) && ({held0_nxt, held1_nxt} == crc_nxt);
    end
    if (in_last) begin
      crc_nxt   = init_value_r;
      held0_nxt = '0;
      held1_nxt = '0;
      cnt_nxt   = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      check_mode_r <= 1'b0;
      init_value_r <= '0;
      crc_r        <= '0;
      held0_r      <= '0;
      held1_r      <= '0;
      cnt_r        <= 2'd0;
    end else begin
      if (in_accept) begin
        held0_r <= held0_nxt;
        held1_r <= held1_nxt;
        cnt_r   <= cnt_nxt;
      end
      // A new start value restarts the accumulation at once.
      if (cfg_wr_en && (cfg_addr == crcfg_pkg::CFG_INIT_VALUE)) begin
        crc_r <= cfg_wdata;
      end else if (in_accept) begin
        crc_r <= crc_nxt;
      end
      if (cfg_wr_en) begin
        case (cfg_addr)
          crcfg_pkg::CFG_CHECK_MODE: check_mode_r <= cfg_wdata[0];
          crcfg_pkg::CFG_INIT_VALUE: init_value_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== hw/rtl/crcfg_rec_fifo.sv =====
module crcfg_rec_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  crcfg_pkg::rec_t      push_rec,
  input  logic                 pop,
  output logic                 not_full,
  output crcfg_pkg::rec_head_t head
);

  crcfg_pkg::rec_t mem_r [2];
  logic            wr_ptr_r, rd_ptr_r;
  logic [1:0]      count_r;

  assign not_full   = (count_r != 2'd2);
  assign head.valid = (count_r != 2'd0);
  assign head.rec   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== hw/rtl/crcfg_emit.sv =====
module crcfg_emit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  crcfg_pkg::rec_head_t          head,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [crcfg_pkg::ByteW-1:0]   out_byte,
  output logic                          out_last,
  output logic [crcfg_pkg::CrcW-1:0]    out_crc,
  output logic                          out_ok
);

  typedef enum logic [1:0] {
    PH_DATA   = 2'd0,
    PH_CRC_HI = 2'd1,
    PH_CRC_LO = 2'd2
  } phase_t;

  crcfg_pkg::rec_t rec_r;
  logic            valid_r;
  phase_t          phase_r;
  logic            done, advance, load;

  assign done    = (rec_r.kind != crcfg_pkg::REC_GEN_END) || (phase_r == PH_CRC_LO);
  assign advance = valid_r && out_ready;
  assign load    = !valid_r || (advance && done);
  assign pop     = load && head.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= PH_DATA;
      rec_r   <= '0;
    end else if (load) begin
      valid_r <= head.valid;
      phase_r <= PH_DATA;
      rec_r   <= head.rec;
    end else if (advance) begin
      case (phase_r)
        PH_DATA:   phase_r <= PH_CRC_HI;
        PH_CRC_HI: phase_r <= PH_CRC_LO;
        default:   phase_r <= PH_DATA;
      endcase
    end
  end

  assign out_valid = valid_r;

  always_comb begin
    out_byte = rec_r.data;
    out_last = 1'b0;
    out_crc  = '0;
    out_ok   = 1'b0;
    case (rec_r.kind)
      crcfg_pkg::REC_GEN_END: begin
        case (phase_r)
          PH_CRC_HI: out_byte = rec_r.crc[15:8];
          PH_CRC_LO: begin
            out_byte = rec_r.crc[7:0];
            out_last = 1'b1;
            out_crc  = rec_r.crc;
          end
          default: ;
        endcase
      end
      crcfg_pkg::REC_CHECK: begin
        out_byte = '0;
        out_last = 1'b1;
        out_crc  = rec_r.crc;
        out_ok   = rec_r.ok;
      end
      default: ;
    endcase
  end

endmodule

// ===== dv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles to wait once nothing is expected any more, so that a check-mode
  // byte still inside the block has settled before a register is written.
  localparam int SettleCycles = 8;
  // Longest run of cycles with no item moved on either side and no register
  // write before the run is declared hung. The longest legal quiet stretch
  // comes from the receiver hold-off below.
  localparam int QuietLimit = 1000;
  // Length of the receiver hold-off used to fill the block and stall its input.
  localparam int HoldCycles = 80;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] data_byte
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;          // [7:0] out_byte, [23:8] crc_value
  logic        out_tlast;
  logic        out_tuser;          // [0] crc_ok
  logic        cfg_wr_en = 1'b0;
  logic        cfg_addr = crcfg_pkg::CFG_CHECK_MODE;
  logic [15:0] cfg_wdata = 16'h0000;

  crc16_frame_generate_check dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // One item on the result channel, field by field.
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [15:0] crc;
    logic        ok;
  } out_item_t;

  // Result items the block still owes, oldest first.
  out_item_t owed_items[$];

  // Our own copy of the block's registers and frame state.
  logic        mdl_check;
  logic [15:0] mdl_init;
  logic [15:0] mdl_crc;
  logic [7:0]  mdl_held [2];
  logic [1:0]  mdl_held_n;

  // Idle percentages for the sender and the receiver, set per test.
  int gap_pct = 22;
  int stall_pct = 22;

  // The test side bumps hold_req to ask for a receiver hold-off; the
  // receiver process alone tracks what it has already served.
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  int fail_count = 0;
  int quiet_cycles = 0;

  // Reflected CRC-16 with polynomial 0xA001, computed bit by bit. This is
  // the same code as the nibble-table form the block uses, reached a
  // different way.
  function automatic logic [15:0] crc16_arc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
    return r;
  endfunction

  // At a frame end the accumulator restarts from the start value and any
  // bytes held back for the trailer are dropped.
  function automatic void restart_frame();
    mdl_crc = mdl_init;
    mdl_held[0] = 8'h00;
    mdl_held[1] = 8'h00;
    mdl_held_n = 2'd0;
  endfunction

  // Works out what one accepted byte causes on the result channel.
  function automatic void predict_frame_step(input logic [7:0] b, input logic last);
    logic [15:0] rx;
    if (!mdl_check) begin
      // Generate: pass the byte through; at the end append CRC high, then low.
      mdl_crc = crc16_arc_byte(mdl_crc, b);
      owed_items.push_back(out_item_t'{b, 1'b0, 16'h0000, 1'b0});
      if (last) begin
        owed_items.push_back(out_item_t'{mdl_crc[15:8], 1'b0, 16'h0000, 1'b0});
        owed_items.push_back(out_item_t'{mdl_crc[7:0], 1'b1, mdl_crc, 1'b0});
        restart_frame();
      end
    end else begin
      // Check: the two newest bytes stay out of the CRC until a third
      // byte pushes the oldest of them in.
      if (mdl_held_n >= 2'd2) begin
        mdl_crc = crc16_arc_byte(mdl_crc, mdl_held[0]);
        mdl_held[0] = mdl_held[1];
        mdl_held[1] = b;
      end else begin
        mdl_held[mdl_held_n[0]] = b;
        mdl_held_n = mdl_held_n + 2'd1;
      end
      if (last) begin
        // The trailer is big-endian; a frame of one byte can never match.
        rx = {mdl_held[0], mdl_held[1]};
        owed_items.push_back(out_item_t'{8'h00, 1'b1, mdl_crc,
                                         (mdl_held_n >= 2'd2) && (rx == mdl_crc)});
        restart_frame();
      end
    end
  endfunction

  // Offers one item from a falling edge, with random idle cycles ahead of
  // it, and returns at the falling edge after the handshake. The valid is
  // left high so that back-to-back items follow with no gap.
  task automatic send_item(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_frame_step(b, last);
    @(negedge clk);
  endtask

  // Drops the valid and waits until every owed item has come out, then waits
  // out the settle time for bytes that cause no result.
  task automatic settle_idle();
    in_tvalid <= 1'b0;
    while (owed_items.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // Register write: the enable is high for one cycle and low again before the task returns.
  task automatic write_reg(input logic addr, input logic [15:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (addr == crcfg_pkg::CFG_CHECK_MODE) begin
      mdl_check = val[0];
    end else begin
      // A new start value takes effect at once, even within a frame.
      mdl_init = val;
      mdl_crc  = val;
    end
    @(negedge clk);
  endtask

  // A frame of n random bytes, the last one flagged.
  task automatic send_raw_frame(input int n);
    for (int i = 0; i < n; i++) send_item(8'($urandom), i == n - 1);
  endtask

  // A check-mode frame: n random message bytes and a big-endian CRC
  // trailer computed from the start value, with one bit flipped if asked.
  task automatic send_check_frame(input int n, input bit corrupt);
    logic [7:0]  bytes_q[$];
    logic [15:0] c;
    c = mdl_init;
    for (int i = 0; i < n; i++) begin
      bytes_q.push_back(8'($urandom));
      c = crc16_arc_byte(c, bytes_q[i]);
    end
    if (corrupt) c = c ^ (16'h0001 << $urandom_range(15));
    bytes_q.push_back(c[15:8]);
    bytes_q.push_back(c[7:0]);
    foreach (bytes_q[i]) send_item(bytes_q[i], i == bytes_q.size() - 1);
  endtask

  // Generate mode after reset: start value zero, the byte extremes as frames
  // of one byte, a three-byte frame, then a frame under the all-ones start value.
  task automatic test_generate_frames();
    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b1);
    send_item(8'h0F, 1'b0);
    send_item(8'hF0, 1'b0);
    send_item(8'hA5, 1'b1);
    settle_idle();
    write_reg(crcfg_pkg::CFG_INIT_VALUE, 16'hFFFF);
    send_item(8'h5A, 1'b0);
    send_item(8'h80, 1'b1);
    settle_idle();
  endtask

  // Check mode: a one-byte frame that must fail, a bare trailer with no
  // message, a good frame and a frame with a damaged trailer.
  task automatic test_check_frames();
    write_reg(crcfg_pkg::CFG_CHECK_MODE, 16'h0001);
    send_item(8'hA5, 1'b1);
    send_check_frame(0, 1'b0);
    send_check_frame(2, 1'b0);
    send_check_frame(2, 1'b1);
    settle_idle();
  endtask

  // Register writes in the middle of a frame: a new start value restarts
  // the accumulation, and a mode change carries the frame state on, with
  // held-back bytes dropped at the frame end.
  task automatic test_config_mid_frame();
    send_item(8'h11, 1'b0);
    send_item(8'h22, 1'b0);
    settle_idle();
    write_reg(crcfg_pkg::CFG_INIT_VALUE, 16'h1D0F);
    send_item(8'h33, 1'b1);
    send_item(8'h44, 1'b0);
    send_item(8'h55, 1'b0);
    send_item(8'h66, 1'b0);
    settle_idle();
    write_reg(crcfg_pkg::CFG_CHECK_MODE, 16'h0000);
    send_item(8'h77, 1'b1);
    send_item(8'h88, 1'b0);
    settle_idle();
    write_reg(crcfg_pkg::CFG_CHECK_MODE, 16'h0001);
    send_item(8'h99, 1'b1);
    settle_idle();
  endtask

  // The receiver stops for a long stretch while the sender keeps offering
  // generate-mode bytes, so the result queue fills and the input stalls.
  task automatic test_output_hold();
    write_reg(crcfg_pkg::CFG_CHECK_MODE, 16'h0000);
    write_reg(crcfg_pkg::CFG_INIT_VALUE, 16'($urandom));
    gap_pct = 0;
    hold_req++;
    send_raw_frame(12);
    send_raw_frame(3);
    gap_pct = 22;
    settle_idle();
  endtask

  // Random phases, each under its own settings. Check-mode phases are
  // mostly frames with a correct trailer, some damaged trailers and some
  // plain noise. One phase runs with no idling on either side.
  task automatic test_random_traffic();
    int sent;
    int pick;
    for (int ph = 0; ph < 8; ph++) begin
      settle_idle();
      write_reg(crcfg_pkg::CFG_CHECK_MODE, {15'h0000, 1'(ph % 2)});
      if (ph == 0) write_reg(crcfg_pkg::CFG_INIT_VALUE, 16'h0000);
      else if (ph == 1) write_reg(crcfg_pkg::CFG_INIT_VALUE, 16'hFFFF);
      else write_reg(crcfg_pkg::CFG_INIT_VALUE, 16'($urandom));
      gap_pct   = (ph == 3) ? 0 : 22;
      stall_pct = (ph == 3) ? 0 : 22;
      sent = 0;
      while (sent < 32) begin
        pick = $urandom_range(99);
        if (!mdl_check) begin
          pick = $urandom_range(1, 8);
          send_raw_frame(pick);
          sent += pick;
        end else if (pick < 70) begin
          pick = $urandom_range(0, 6);
          send_check_frame(pick, 1'b0);
          sent += pick + 2;
        end else if (pick < 85) begin
          pick = $urandom_range(0, 6);
          send_check_frame(pick, 1'b1);
          sent += pick + 2;
        end else begin
          pick = $urandom_range(1, 4);
          send_raw_frame(pick);
          sent += pick;
        end
      end
    end
    gap_pct   = 22;
    stall_pct = 22;
    settle_idle();
  endtask

  // Receiver: random stalls, or a solid hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Each accepted result item is compared with the oldest owed item.
  always @(posedge clk) begin
    out_item_t got;
    out_item_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_item_t'{out_tdata[7:0], out_tlast, out_tdata[23:8], out_tuser};
      if (owed_items.size() == 0) begin
        $display("%0t: unexpected result item, expected none, actual %h", $time, got);
        fail_count++;
      end else begin
        want = owed_items.pop_front();
        check_field("out_byte", 16'(want.data), 16'(got.data));
        check_field("out_last", 16'(want.last), 16'(got.last));
        check_field("crc_value", want.crc, got.crc);
        check_field("crc_ok", 16'(want.ok), 16'(got.ok));
      end
    end
  end

  // Watchdog: any handshake or register write counts as progress.
  always @(posedge clk) begin
    if (rst_n && ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t: no progress for %0d cycles", $time, QuietLimit);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    mdl_check = 1'b0;
    mdl_init  = 16'h0000;
    restart_frame();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_generate_frames();
    test_check_frames();
    test_config_mid_frame();
    test_output_hold();
    test_random_traffic();

    // settle_idle has already waited out the owed items and the tail.
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/crcfg_pkg.sv
hw/rtl/crcfg_core.sv
hw/rtl/crcfg_rec_fifo.sv
hw/rtl/crcfg_emit.sv
hw/rtl/crc16_frame_generate_check.sv
dv/testbench.sv
